// File: rtl/core/igcd_pkg.sv
// Package for the integer GCD block: payload types, microcode word format,
// datapath status flags and the microprogram ROM.
// No dependencies; every other file of the block imports it.
package igcd_pkg;

  // Datapath width default and fixed channel field widths
  localparam int IGCD_WIDTH = 32;
  localparam int OPERAND_W  = 32;
  localparam int DIVISOR_W  = 32;

  // Microprogram counter
  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] upc_t;

  // Channel payloads
  typedef struct packed {
    logic [OPERAND_W-1:0] first_value;
    logic [OPERAND_W-1:0] second_value;
    logic                 action;
  } in_item_t;

  typedef struct packed {
    logic [DIVISOR_W-1:0] divisor;
  } out_item_t;

  // Method selector codes
  localparam logic ACT_EUCLID = 1'b0;
  localparam logic ACT_BINARY = 1'b1;

  // Sequencer state
  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Register operations driven by the control word
  typedef enum logic [2:0] {
    X_HOLD,
    X_SUB_D,    // x -= d when x >= d (one restoring remainder step)
    X_FROM_Y,
    X_SHR,
    X_SHL,
    X_SUB_MIN   // x -= y when x > y
  } x_op_t;

  typedef enum logic [1:0] {
    Y_HOLD,
    Y_FROM_X,
    Y_SHR,
    Y_SUB_MIN   // y -= x when x <= y
  } y_op_t;

  typedef enum logic [1:0] {
    D_HOLD,
    D_FROM_Y,
    D_SHL,
    D_SHR
  } d_op_t;

  typedef enum logic [1:0] {
    K_HOLD,
    K_INC,
    K_DEC
  } k_op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_X_ZERO,
    C_Y_ZERO,
    C_XY_ODD,
    C_X_ODD,
    C_Y_ODD,
    C_X_EQ_Y,
    C_D_GT_HALF,
    C_D_EQ_Y,
    C_K_ZERO
  } cond_t;

  // One control word
  typedef struct packed {
    x_op_t x_op;
    y_op_t y_op;
    d_op_t d_op;
    k_op_t k_op;
    cond_t cond;
    upc_t  target;
    logic  emit;
  } uword_t;

  // Flags from the datapath to the sequencer
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic xy_odd;
    logic x_odd;
    logic y_odd;
    logic x_eq_y;
    logic d_gt_half;
    logic d_eq_y;
    logic k_zero;
  } status_t;

  localparam uword_t UWORD_NOP = '{
    x_op:   X_HOLD,
    y_op:   Y_HOLD,
    d_op:   D_HOLD,
    k_op:   K_HOLD,
    cond:   C_NEVER,
    target: '0,
    emit:   1'b0
  };

  // Program addresses
  localparam upc_t UPC_E_TEST   = upc_t'(0);   // Euclid: stop when y is zero
  localparam upc_t UPC_E_LOAD   = upc_t'(1);
  localparam upc_t UPC_E_ALIGN  = upc_t'(2);
  localparam upc_t UPC_E_DBL    = upc_t'(3);
  localparam upc_t UPC_E_REDUCE = upc_t'(4);
  localparam upc_t UPC_E_HALVE  = upc_t'(5);
  localparam upc_t UPC_E_SWAP   = upc_t'(6);
  localparam upc_t UPC_FIX      = upc_t'(7);   // shift common twos back in
  localparam upc_t UPC_FIX_SHL  = upc_t'(8);
  localparam upc_t UPC_EMIT     = upc_t'(9);
  localparam upc_t UPC_B_START  = upc_t'(10);  // binary method entry
  localparam upc_t UPC_B_YZERO  = upc_t'(11);
  localparam upc_t UPC_B_TWOS   = upc_t'(12);
  localparam upc_t UPC_B_STRIP  = upc_t'(13);
  localparam upc_t UPC_B_XODD   = upc_t'(14);
  localparam upc_t UPC_B_XSHR   = upc_t'(15);
  localparam upc_t UPC_B_YODD   = upc_t'(16);
  localparam upc_t UPC_B_YSHR   = upc_t'(17);
  localparam upc_t UPC_B_EQ     = upc_t'(18);
  localparam upc_t UPC_B_SUB    = upc_t'(19);
  localparam upc_t UPC_B_XZERO  = upc_t'(20);

  // Microprogram ROM: ops apply every step, a met condition jumps to target
  function automatic uword_t ucode_rom(upc_t upc);
    uword_t w;
    w = UWORD_NOP;
    case (upc)
      UPC_E_TEST: begin
        w.cond = C_Y_ZERO;  w.target = UPC_FIX;
      end
      UPC_E_LOAD: begin
        w.d_op = D_FROM_Y;
      end
      UPC_E_ALIGN: begin
        w.cond = C_D_GT_HALF;  w.target = UPC_E_REDUCE;
      end
      UPC_E_DBL: begin
        w.d_op = D_SHL;  w.cond = C_ALWAYS;  w.target = UPC_E_ALIGN;
      end
      UPC_E_REDUCE: begin
        w.x_op = X_SUB_D;  w.cond = C_D_EQ_Y;  w.target = UPC_E_SWAP;
      end
      UPC_E_HALVE: begin
        w.d_op = D_SHR;  w.cond = C_ALWAYS;  w.target = UPC_E_REDUCE;
      end
      UPC_E_SWAP: begin
        w.x_op = X_FROM_Y;  w.y_op = Y_FROM_X;
        w.cond = C_ALWAYS;  w.target = UPC_E_TEST;
      end
      UPC_FIX: begin
        w.cond = C_K_ZERO;  w.target = UPC_EMIT;
      end
      UPC_FIX_SHL: begin
        w.x_op = X_SHL;  w.k_op = K_DEC;  w.cond = C_ALWAYS;  w.target = UPC_FIX;
      end
      UPC_EMIT: begin
        w.emit = 1'b1;
      end
      UPC_B_START: begin
        w.cond = C_X_ZERO;  w.target = UPC_B_XZERO;
      end
      UPC_B_YZERO: begin
        w.cond = C_Y_ZERO;  w.target = UPC_FIX;
      end
      UPC_B_TWOS: begin
        w.cond = C_XY_ODD;  w.target = UPC_B_XODD;
      end
      UPC_B_STRIP: begin
        w.x_op = X_SHR;  w.y_op = Y_SHR;  w.k_op = K_INC;
        w.cond = C_ALWAYS;  w.target = UPC_B_TWOS;
      end
      UPC_B_XODD: begin
        w.cond = C_X_ODD;  w.target = UPC_B_YODD;
      end
      UPC_B_XSHR: begin
        w.x_op = X_SHR;  w.cond = C_ALWAYS;  w.target = UPC_B_XODD;
      end
      UPC_B_YODD: begin
        w.cond = C_Y_ODD;  w.target = UPC_B_EQ;
      end
      UPC_B_YSHR: begin
        w.y_op = Y_SHR;  w.cond = C_ALWAYS;  w.target = UPC_B_YODD;
      end
      UPC_B_EQ: begin
        w.cond = C_X_EQ_Y;  w.target = UPC_FIX;
      end
      UPC_B_SUB: begin
        w.x_op = X_SUB_MIN;  w.y_op = Y_SUB_MIN;
        w.cond = C_ALWAYS;  w.target = UPC_B_XODD;
      end
      UPC_B_XZERO: begin
        w.x_op = X_FROM_Y;  w.cond = C_ALWAYS;  w.target = UPC_FIX;
      end
      default: begin
        w.cond = C_ALWAYS;  w.target = UPC_EMIT;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/igcd_if.sv
// Valid/ready channel interfaces for the integer GCD block: operand
// channel and result channel. Depends on igcd_pkg for the payload types.
interface igcd_in_if import igcd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface igcd_out_if import igcd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/igcd_useq.sv
// Microcode sequencer: program counter, ROM fetch, condition test and jump.
// Depends on igcd_pkg for the control word, status flags and ROM.
module igcd_useq import igcd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    start_sel,
  input  status_t status,
  input  logic    out_free,
  output logic    idle,
  output uword_t  ctrl,
  output logic    fire
);

  seq_state_t state, state_next;
  upc_t       upc, upc_next;
  uword_t     uw;
  logic       cond_met;

  // ROM fetch
  assign uw = ucode_rom(upc);

  // Jump condition select
  always_comb begin
    case (uw.cond)
      C_NEVER:     cond_met = 1'b0;
      C_ALWAYS:    cond_met = 1'b1;
      C_X_ZERO:    cond_met = status.x_zero;
      C_Y_ZERO:    cond_met = status.y_zero;
      C_XY_ODD:    cond_met = status.xy_odd;
      C_X_ODD:     cond_met = status.x_odd;
      C_Y_ODD:     cond_met = status.y_odd;
      C_X_EQ_Y:    cond_met = status.x_eq_y;
      C_D_GT_HALF: cond_met = status.d_gt_half;
      C_D_EQ_Y:    cond_met = status.d_eq_y;
      C_K_ZERO:    cond_met = status.k_zero;
      default:     cond_met = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: if (start) state_next = SEQ_RUN;
      SEQ_RUN:  if (fire) state_next = SEQ_IDLE;
      default:  state_next = SEQ_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    idle = (state == SEQ_IDLE);
    ctrl = (state == SEQ_RUN) ? uw : UWORD_NOP;
    fire = (state == SEQ_RUN) && uw.emit && out_free;
  end

  // Program counter; the emit step holds until the result register is free
  always_comb begin
    upc_next = upc;
    if (start) begin
      upc_next = (start_sel == ACT_BINARY) ? UPC_B_START : UPC_E_TEST;
    end else if (state == SEQ_RUN && !uw.emit) begin
      upc_next = cond_met ? uw.target : upc_t'(upc + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      upc   <= UPC_E_TEST;
    end else begin
      state <= state_next;
      upc   <= upc_next;
    end
  end

endmodule

// File: rtl/core/igcd_dpath.sv
// Datapath of the integer GCD block: operand registers x and y, aligned
// divisor d, shift count k, one subtractor pair and shifters.
// Depends on igcd_pkg for the control word and status flag types.
module igcd_dpath import igcd_pkg::*; #(
  parameter int WIDTH = IGCD_WIDTH
) (
  input  logic             clk,
  input  logic             load,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  uword_t           ctrl,
  output status_t          status,
  output logic [WIDTH-1:0] result
);

  localparam int K_W = $clog2(WIDTH);

  logic [WIDTH-1:0] x, x_next;
  logic [WIDTH-1:0] y, y_next;
  logic [WIDTH-1:0] d, d_next;
  logic [K_W-1:0]   k, k_next;
  logic             x_ge_d;
  logic             x_gt_y;

  assign x_ge_d = (x >= d);
  assign x_gt_y = (x > y);

  // Register updates
  always_comb begin
    case (ctrl.x_op)
      X_HOLD:    x_next = x;
      X_SUB_D:   x_next = x_ge_d ? x - d : x;
      X_FROM_Y:  x_next = y;
      X_SHR:     x_next = x >> 1;
      X_SHL:     x_next = x << 1;
      X_SUB_MIN: x_next = x_gt_y ? x - y : x;
      default:   x_next = x;
    endcase

    case (ctrl.y_op)
      Y_HOLD:    y_next = y;
      Y_FROM_X:  y_next = x_next;
      Y_SHR:     y_next = y >> 1;
      Y_SUB_MIN: y_next = x_gt_y ? y : y - x;
      default:   y_next = y;
    endcase

    case (ctrl.d_op)
      D_HOLD:   d_next = d;
      D_FROM_Y: d_next = y;
      D_SHL:    d_next = d << 1;
      D_SHR:    d_next = d >> 1;
      default:  d_next = d;
    endcase

    case (ctrl.k_op)
      K_HOLD:  k_next = k;
      K_INC:   k_next = K_W'(k + 1'b1);
      K_DEC:   k_next = K_W'(k - 1'b1);
      default: k_next = k;
    endcase
  end

  // Load or update; on the swap step y takes the old x (remainder) while x takes y
  always_ff @(posedge clk) begin
    if (load) begin
      x <= a;
      y <= b;
      k <= '0;
    end else begin
      x <= x_next;
      y <= (ctrl.y_op == Y_FROM_X) ? x : y_next;
      k <= k_next;
    end
    d <= d_next;
  end

  // Flags for the sequencer
  always_comb begin
    status.x_zero    = (x == '0);
    status.y_zero    = (y == '0);
    status.xy_odd    = x[0] | y[0];
    status.x_odd     = x[0];
    status.y_odd     = y[0];
    status.x_eq_y    = (x == y);
    status.d_gt_half = (d > (x >> 1));
    status.d_eq_y    = (d == y);
    status.k_zero    = (k == '0);
  end

  assign result = x;

endmodule

// File: rtl/core/integer_gcd_top.sv
// Integer GCD block, top level: channel handshakes, result register and
// the sequencer and datapath. Depends on igcd_pkg, igcd_if, igcd_useq and
// igcd_dpath.
//
// Takes two unsigned operands and a method bit and returns their greatest
// common divisor (zero when both are zero). One item is worked at a time;
// in_ch.ready is high while the sequencer is idle. The cost is set by the
// microprogram, one control step per clock except while the emit step
// waits for the result register: method 0 (Euclid) aligns the divisor,
// then subtracts and halves it for each remainder step and swaps;
// method 1 (binary) strips common factors of two, shifts out the other
// twos of each operand and subtracts, and then shifts the common twos back
// in. The result register lets the next item start while a finished
// result waits.
module integer_gcd_top import igcd_pkg::*; #(
  parameter int WIDTH = IGCD_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  igcd_in_if.sink    in_ch,
  igcd_out_if.source out_ch
);

  logic             idle;
  logic             start;
  logic             fire;
  logic             out_free;
  uword_t           ctrl;
  status_t          status;
  logic [WIDTH-1:0] op_a;
  logic [WIDTH-1:0] op_b;
  logic [WIDTH-1:0] result;
  logic             out_valid;
  logic [DIVISOR_W-1:0] out_data;

  // Input transfer
  assign in_ch.ready = idle;
  assign start       = in_ch.valid && idle;
  assign op_a        = WIDTH'(in_ch.payload.first_value);
  assign op_b        = WIDTH'(in_ch.payload.second_value);

  igcd_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .start_sel (in_ch.payload.action),
    .status    (status),
    .out_free  (out_free),
    .idle      (idle),
    .ctrl      (ctrl),
    .fire      (fire)
  );

  igcd_dpath #(.WIDTH(WIDTH)) u_dpath (
    .clk    (clk),
    .load   (start),
    .a      (op_a),
    .b      (op_b),
    .ctrl   (ctrl),
    .status (status),
    .result (result)
  );

  // Result register
  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= DIVISOR_W'(result);
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.payload.divisor = out_data;

  // A result is handed over only once all common twos are restored
  a_emit_restored: assert property (@(posedge clk) disable iff (rst)
    fire |-> status.k_zero)
    else $error("result emitted with shift count pending");

  // An emitted result is presented on the next cycle
  a_emit_shown: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_ch.valid)
    else $error("emitted result not presented");

  // An accepted item occupies the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("new item taken while one is in progress");

endmodule
